[rtl/core/path_command_bezier_flattener_unit_defines.svh]
// ----------------------------------------------------------------------------
// Path command Bezier flattener - assertion macros
// Shared property wrappers for the checker of the flattener unit.
// ----------------------------------------------------------------------------
`ifndef PATH_COMMAND_BEZIER_FLATTENER_UNIT_DEFINES_SVH
`define PATH_COMMAND_BEZIER_FLATTENER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pbf_pkg.sv]
// ----------------------------------------------------------------------------
// pbf_pkg
// Types, widths, codes and Bernstein weights shared by the flattener.
// ----------------------------------------------------------------------------
package pbf_pkg;

    // default fixed-point formats
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // points per flattened curve, one lane each
    localparam int SEGMENTS  = 4;
    localparam int SEG_IDX_W = $clog2(SEGMENTS);
    localparam int CTRL_PTS  = 4;
    localparam int MAP_LANES = 3;

    // field widths
    localparam int FUNC_W  = 3;
    localparam int RAW_W   = 24;
    localparam int SCALE_W = 20;
    localparam int OFS_W   = 16;
    localparam int DSIZE_W = 12;
    localparam int PT_W    = 40;
    localparam int PIX_W   = 16;
    localparam int WGT_W   = 7;
    localparam int WGT_SH  = 6;
    localparam int SUM_W   = PT_W + WGT_SH;

    // configuration port
    localparam int NUM_REGS = 4;
    localparam int PADDR_W  = $clog2(NUM_REGS) + 2;
    localparam int PDATA_W  = 32;

    // register reset values
    localparam logic [SCALE_W-1:0]        SCALE_RST = SCALE_W'(65536);
    localparam logic signed [OFS_W-1:0]   OFS_RST   = '0;
    localparam logic [DSIZE_W-1:0]        DSIZE_RST = DSIZE_W'(280);

    // register index codes
    typedef enum logic [$clog2(NUM_REGS)-1:0] {
        REG_SCALE = 2'd0,
        REG_OFF_X = 2'd1,
        REG_OFF_Y = 2'd2,
        REG_DSIZE = 2'd3
    } t_reg;

    // command codes
    typedef enum logic [FUNC_W-1:0] {
        F_MOVE    = 3'd0,
        F_LINE    = 3'd1,
        F_CURVE   = 3'd2,
        F_CURVE_S = 3'd3,
        F_CURVE_T = 3'd4
    } t_func;

    // per-stage control travelling with the point data
    typedef struct packed {
        logic              vld;
        logic [FUNC_W-1:0] func;
    } t_ctl;

    // Bernstein weights x64 at t = 1/4, 1/2, 3/4 and the end point
    localparam logic [WGT_W-1:0] BEZ_W [SEGMENTS][CTRL_PTS] = '{
        '{7'd27, 7'd27, 7'd9,  7'd1},
        '{7'd8,  7'd24, 7'd24, 7'd8},
        '{7'd1,  7'd9,  7'd27, 7'd27},
        '{7'd0,  7'd0,  7'd0,  7'd64}
    };

    function automatic logic func_known(input logic [FUNC_W-1:0] f);
        return f inside {F_MOVE, F_LINE, F_CURVE, F_CURVE_S, F_CURVE_T};
    endfunction

    function automatic logic func_curve(input logic [FUNC_W-1:0] f);
        return f inside {F_CURVE, F_CURVE_S, F_CURVE_T};
    endfunction

endpackage

[rtl/core/pbf_map_lane.sv]
// ----------------------------------------------------------------------------
// pbf_map_lane
// Maps one path point to display space: scale, offset, y flip, saturate.
// ----------------------------------------------------------------------------
module pbf_map_lane
    import pbf_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_adv,
    input  logic signed [RAW_W-1:0]   i_raw_x,
    input  logic signed [RAW_W-1:0]   i_raw_y,
    input  logic [SCALE_W-1:0]        i_scale,
    input  logic signed [OFS_W-1:0]   i_off_x,
    input  logic signed [OFS_W-1:0]   i_off_y,
    input  logic [DSIZE_W-1:0]        i_dsize,
    output logic signed [PT_W-1:0]    o_pt_x,
    output logic signed [PT_W-1:0]    o_pt_y
);

    localparam int PROD_W = RAW_W + SCALE_W + 1;
    localparam int MSUM_W = PROD_W + 2;
    localparam int BASE_W = OFS_W + 2;

    logic signed [PROD_W-1:0] r_prod_x, r_prod_y;
    logic signed [PROD_W-1:0] n_prod_x, n_prod_y;
    logic signed [PT_W-1:0]   r_pt_x, r_pt_y;
    logic signed [PT_W-1:0]   n_pt_x, n_pt_y;
    logic signed [PROD_W-1:0] sh_x, sh_y;
    logic signed [BASE_W-1:0] base_y;
    logic signed [MSUM_W-1:0] sum_x, sum_y;

    // saturate a wide mapped value to the point width
    function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [MSUM_W-1:0] v);
        logic [MSUM_W-PT_W:0] hi;
        hi = v[MSUM_W-1:PT_W-1];
        if ((&hi) || !(|hi)) begin
            return v[PT_W-1:0];
        end else if (v[MSUM_W-1]) begin
            return {1'b1, {(PT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(PT_W-1){1'b1}}};
        end
    endfunction

    // multiply by the scale factor
    always_comb begin
        n_prod_x = PROD_W'(i_raw_x) * PROD_W'($signed({1'b0, i_scale}));
        n_prod_y = PROD_W'(i_raw_y) * PROD_W'($signed({1'b0, i_scale}));
    end

    // drop coordinate fraction (floor), add offsets, flip y
    always_comb begin
        sh_x   = r_prod_x >>> COORD_FRAC_BITS;
        sh_y   = r_prod_y >>> COORD_FRAC_BITS;
        base_y = BASE_W'($signed({1'b0, i_dsize})) + BASE_W'(i_off_y);
        sum_x  = MSUM_W'(sh_x) + (MSUM_W'(i_off_x) <<< SCALE_FRAC_BITS);
        sum_y  = (MSUM_W'(base_y) <<< SCALE_FRAC_BITS) - MSUM_W'(sh_y);
        n_pt_x = sat_pt(sum_x);
        n_pt_y = sat_pt(sum_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_pt_x   <= n_pt_x;
            r_pt_y   <= n_pt_y;
        end
    end

    assign o_pt_x = r_pt_x;
    assign o_pt_y = r_pt_y;

endmodule

[rtl/core/pbf_bez_lane.sv]
// ----------------------------------------------------------------------------
// pbf_bez_lane
// Evaluates one fixed Bernstein point of the curve and converts it to pixels.
// ----------------------------------------------------------------------------
module pbf_bez_lane
    import pbf_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
    parameter int LANE            = 0
) (
    input  logic                     i_clk,
    input  logic                     i_adv,
    input  logic signed [PT_W-1:0]   i_pts [2][CTRL_PTS],
    output logic signed [PIX_W-1:0]  o_pix [2]
);

    localparam int SHIFT = SCALE_FRAC_BITS + WGT_SH;
    localparam logic [SUM_W-1:0] Q_POS_LIM = SUM_W'(2 ** (PIX_W - 1) - 1);
    localparam logic [SUM_W-1:0] Q_NEG_LIM = SUM_W'(2 ** (PIX_W - 1));

    logic signed [SUM_W-1:0]  r_term [2][CTRL_PTS];
    logic signed [SUM_W-1:0]  r_sum  [2];
    logic signed [PIX_W-1:0]  r_pix  [2];
    logic signed [SUM_W-1:0]  n_term [2][CTRL_PTS];
    logic signed [SUM_W-1:0]  n_sum  [2];
    logic signed [PIX_W-1:0]  n_pix  [2];
    logic [SUM_W-1:0]         mag    [2];
    logic [SUM_W-1:0]         quo    [2];

    // weight each control point
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int j = 0; j < CTRL_PTS; j++) begin
                n_term[a][j] = SUM_W'(i_pts[a][j]) * SUM_W'($signed({1'b0, BEZ_W[LANE][j]}));
            end
        end
    end

    // add the weighted terms
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_sum[a] = r_term[a][0] + r_term[a][1] + r_term[a][2] + r_term[a][3];
        end
    end

    // truncate toward zero and saturate to pixel range
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            mag[a] = r_sum[a][SUM_W-1] ? (~r_sum[a] + SUM_W'(1)) : r_sum[a];
            quo[a] = mag[a] >> SHIFT;
            if (r_sum[a][SUM_W-1]) begin
                n_pix[a] = (quo[a] > Q_NEG_LIM) ? {1'b1, {(PIX_W-1){1'b0}}}
                                                : -quo[a][PIX_W-1:0];
            end else begin
                n_pix[a] = (quo[a] > Q_POS_LIM) ? {1'b0, {(PIX_W-1){1'b1}}}
                                                : quo[a][PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_term <= n_term;
            r_sum  <= n_sum;
            r_pix  <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

[rtl/core/pbf_out_merge.sv]
// ----------------------------------------------------------------------------
// pbf_out_merge
// Collects the lane results of one command and sends them out beat by beat.
// ----------------------------------------------------------------------------
module pbf_out_merge
    import pbf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic signed [PIX_W-1:0]  i_pix [2][SEGMENTS],
    output logic                     o_take,
    output logic                     o_tvalid,
    input  logic                     i_tready,
    output logic signed [PIX_W-1:0]  o_pix_x,
    output logic signed [PIX_W-1:0]  o_pix_y,
    output logic                     o_kind,
    output logic                     o_last
);

    localparam logic [SEG_IDX_W-1:0] IDX_LAST = SEG_IDX_W'(SEGMENTS - 1);

    logic                     r_vld;
    logic [SEG_IDX_W-1:0]     r_idx;
    logic                     r_kind;
    logic signed [PIX_W-1:0]  r_pix [2][SEGMENTS];
    logic                     last;

    assign last   = (r_idx == IDX_LAST);
    assign o_take = !r_vld || (i_tready && last);

    // load a finished command, step through its points
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= IDX_LAST;
        end else if (o_take) begin
            r_vld <= i_ctl.vld;
            r_idx <= func_curve(i_ctl.func) ? '0 : IDX_LAST;
        end else if (i_tready) begin
            r_idx <= r_idx + SEG_IDX_W'(1);
        end
    end

    // hold point payload of the command on show
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pix  <= i_pix;
            r_kind <= (i_ctl.func != F_MOVE);
        end
    end

    assign o_tvalid = r_vld;
    assign o_pix_x  = r_pix[0][r_idx];
    assign o_pix_y  = r_pix[1][r_idx];
    assign o_kind   = r_kind;
    assign o_last   = last;

endmodule

[rtl/core/path_command_bezier_flattener_unit.sv]
// ----------------------------------------------------------------------------
// path_command_bezier_flattener_unit
// Turns path commands into display-space pen points, curves into four lines.
// ----------------------------------------------------------------------------
// A move or line command gives one output beat; a curve command gives four
// line-to beats (t = 1/4, 1/2, 3/4 and the end point), the last one marked by
// m_tlast. Commands with unknown codes are taken and give nothing. A new
// command is taken every cycle while results flow; the output stage sends one
// point per beat and holds a curve, and the pipeline, until its last point is
// accepted. A taken command passes two mapping lane registers, one control
// point selection register, three Bernstein lane registers and one output
// stage register before its first beat. The user must write registers over
// the APB port only while no command is in flight; the block does not check.
// ----------------------------------------------------------------------------
module path_command_bezier_flattener_unit
    import pbf_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [143:0]        s_tdata,   // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y
    input  logic [FUNC_W-1:0]   s_tuser,   // func
    // point stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // pixel_x, pixel_y
    output logic                m_tuser,   // draw_kind
    output logic                m_tlast,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int NSTG = 6;

    logic [SCALE_W-1:0]        r_scale;
    logic signed [OFS_W-1:0]   r_off_x, r_off_y;
    logic [DSIZE_W-1:0]        r_dsize;
    t_reg                      reg_sel;

    t_ctl                      r_ctl [NSTG];
    logic                      adv;
    logic                      take;

    logic signed [RAW_W-1:0]   raw [MAP_LANES][2];
    logic signed [PT_W-1:0]    map_pt [MAP_LANES][2];
    logic signed [PT_W-1:0]    r_cur [2];
    logic signed [PT_W-1:0]    n_sel [2][CTRL_PTS];
    logic signed [PT_W-1:0]    r_sel [2][CTRL_PTS];
    logic signed [PIX_W-1:0]   lane_pix [2][SEGMENTS];
    logic signed [PIX_W-1:0]   out_x, out_y;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
            r_off_x <= OFS_RST;
            r_off_y <= OFS_RST;
            r_dsize <= DSIZE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                REG_OFF_X: r_off_x <= pwdata[OFS_W-1:0];
                REG_OFF_Y: r_off_y <= pwdata[OFS_W-1:0];
                REG_DSIZE: r_dsize <= pwdata[DSIZE_W-1:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SCALE: prdata = PDATA_W'(r_scale);
            REG_OFF_X: prdata = PDATA_W'(r_off_x);
            REG_OFF_Y: prdata = PDATA_W'(r_off_y);
            REG_DSIZE: prdata = PDATA_W'(r_dsize);
            default:   prdata = '0;
        endcase
    end

    // whole pipeline moves when its tail can hand over
    assign adv      = !r_ctl[NSTG-1].vld || take;
    assign s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (adv) begin
            r_ctl[0] <= '{vld: s_tvalid && func_known(s_tuser), func: s_tuser};
            for (int k = 1; k < NSTG; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // mapping lanes, one per input point
    always_comb begin
        for (int l = 0; l < MAP_LANES; l++) begin
            raw[l][0] = s_tdata[(2*l)*RAW_W +: RAW_W];
            raw[l][1] = s_tdata[(2*l+1)*RAW_W +: RAW_W];
        end
    end

    for (genvar l = 0; l < MAP_LANES; l++) begin : g_map
        pbf_map_lane #(
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
        ) u_map (
            .i_clk   (i_clk),
            .i_adv   (adv),
            .i_raw_x (raw[l][0]),
            .i_raw_y (raw[l][1]),
            .i_scale (r_scale),
            .i_off_x (r_off_x),
            .i_off_y (r_off_y),
            .i_dsize (r_dsize),
            .o_pt_x  (map_pt[l][0]),
            .o_pt_y  (map_pt[l][1])
        );
    end

    // pick control points by command, current point as start of a curve
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            case (t_func'(r_ctl[1].func))
                F_CURVE: begin
                    n_sel[a][0] = r_cur[a];
                    n_sel[a][1] = map_pt[0][a];
                    n_sel[a][2] = map_pt[1][a];
                    n_sel[a][3] = map_pt[2][a];
                end
                F_CURVE_S: begin
                    n_sel[a][0] = r_cur[a];
                    n_sel[a][1] = r_cur[a];
                    n_sel[a][2] = map_pt[0][a];
                    n_sel[a][3] = map_pt[1][a];
                end
                F_CURVE_T: begin
                    n_sel[a][0] = r_cur[a];
                    n_sel[a][1] = map_pt[0][a];
                    n_sel[a][2] = map_pt[1][a];
                    n_sel[a][3] = map_pt[1][a];
                end
                default: begin
                    for (int j = 0; j < CTRL_PTS; j++) begin
                        n_sel[a][j] = map_pt[0][a];
                    end
                end
            endcase
        end
    end

    // advance the current point as each command passes selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur[0] <= '0;
            r_cur[1] <= '0;
        end else if (adv && r_ctl[1].vld) begin
            r_cur[0] <= n_sel[0][CTRL_PTS-1];
            r_cur[1] <= n_sel[1][CTRL_PTS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sel <= n_sel;
        end
    end

    // Bernstein lanes, one per output point
    for (genvar s = 0; s < SEGMENTS; s++) begin : g_bez
        logic signed [PIX_W-1:0] pix [2];

        pbf_bez_lane #(
            .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
            .LANE            (s)
        ) u_bez (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_pts (r_sel),
            .o_pix (pix)
        );

        assign lane_pix[0][s] = pix[0];
        assign lane_pix[1][s] = pix[1];
    end

    // merge lane results into the output stream
    pbf_out_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl[NSTG-1]),
        .i_pix    (lane_pix),
        .o_take   (take),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_pix_x  (out_x),
        .o_pix_y  (out_y),
        .o_kind   (m_tuser),
        .o_last   (m_tlast)
    );

    assign m_tdata = {out_y, out_x};

endmodule

[rtl/core/pbf_checker.sv]
// ----------------------------------------------------------------------------
// pbf_checker
// Port-level checks on the flattener output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "path_command_bezier_flattener_unit_defines.svh"

module pbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled beat holds its point
    `PBF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

    // only curves give more than one beat, and those are all line-to
    `PBF_ASSERT_NOW(a_mid_line, i_clk, i_rst_n, m_tvalid && !m_tlast, m_tuser, "non-final beat is not a line")

    // a curve's points follow without a gap
    `PBF_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a curve")

    // nothing on show straight out of reset
    `PBF_ASSERT_NOW(a_rst_idle, i_clk, i_rst_n, $rose(i_rst_n), !m_tvalid, "beat shown after reset")

endmodule

bind path_command_bezier_flattener_unit pbf_checker u_pbf_checker (.*);
